FILE: sv/gscm_pkg.sv
// Package for the curved segment midpoint unit: widths, codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package gscm_pkg;
  localparam int LINE_DEPTH = 256;
  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = 32;

  typedef logic [2:0] fit_t;
  localparam fit_t FIT_NONE  = 3'd0;
  localparam fit_t FIT_TWO   = 3'd1;
  localparam fit_t FIT_LEFT  = 3'd2;
  localparam fit_t FIT_RIGHT = 3'd3;
  localparam fit_t FIT_LREJ  = 3'd4;
  localparam fit_t FIT_RREJ  = 3'd5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {NB_DEGEN = 2'd0, NB_REJECT = 2'd1, NB_OK = 2'd2} nb_t;

  // neighbour test request / response between top and tester
  typedef struct packed {
    logic start;
    logic signed [32:0] p0, p1, p2;
    logic signed [32:0] q0, q1, q2;
  } nbt_req_t;

  typedef struct packed {
    logic done;
    nb_t  res;
  } nbt_rsp_t;
endpackage

FILE: sv/grid_segment_curved_midpoint_unit.sv
// Top level of the curved segment midpoint unit: line store, query sequencer, APB regs.
// Depends on gscm_pkg and gscm_nbtest.
//
//  channel | direction | words                                   | handshake
//  in_     | input     | op, point_index, coord_x/y/z            | valid/ready
//  out_    | output    | mid_x/y/z, fit_case                     | valid/ready
//  cfg_    | input     | left_limit (0x0), right_limit (0x4)     | APB, pready=1
//
// A write is accepted in S_IDLE, then the store port writes it in S_WR.
// A query reads points j-1..j+2 through the single-port store, one a cycle,
// then runs up to two neighbour tests in the shared tester (each: start,
// 9 sum products, 14 limb products and a decision, done).
// Reset clears control state and limits; the store stays undefined until written.
// A result waits in the output register; the next word is taken only once it is gone.
`timescale 1ns / 1ps
module grid_segment_curved_midpoint_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_point_index,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_mid_x,
  output logic signed [31:0] out_mid_y,
  output logic signed [31:0] out_mid_z,
  output logic [2:0]  out_fit_case,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gscm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_WR = 8'b00000010, S_RD = 8'b00000100,
    S_DEC = 8'b00001000, S_T1 = 8'b00010000, S_T2 = 8'b00100000,
    S_CALC = 8'b01000000, S_OUT = 8'b10000000
  } st_t;

  st_t st_r, st_nxt;
  logic [7:0] left_r, right_r;
  logic [7:0] j_r;
  logic [2:0] rk_r;             // read step 0..4
  logic [95:0] wdata_r;
  logic [95:0] mem [LINE_DEPTH];
  logic [95:0] rdata_r;
  logic signed [31:0] pt_r [4][3];
  logic use1_r, use2_r, second_r;
  fit_t code_r;
  nbt_req_t req;
  nbt_rsp_t rsp;

  // APB: always ready, register 0/1 at byte 0/4
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      1'b0: prdata = {24'd0, left_r};
      default: prdata = {24'd0, right_r};
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0; right_r <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == 3'd0) left_r <= pwdata[7:0];
      else if (paddr == 3'd4) right_r <= pwdata[7:0];
    end
  end

  // store port: write in S_WR, else read the address of the current step
  logic [AW-1:0] raddr;
  assign raddr = AW'(j_r + 8'(rk_r) - 8'd1);
  always_ff @(posedge clk) begin
    if (st_r == S_WR) mem[AW'(j_r)] <= wdata_r;
    else rdata_r <= mem[raddr];
  end

  // differences for the tester
  logic signed [32:0] dp [3], dq [3], dr [3];
  always_comb
    for (int i = 0; i < 3; i++) begin
      dp[i] = 33'(pt_r[2][i]) - 33'(pt_r[1][i]);
      dq[i] = 33'(pt_r[1][i]) - 33'(pt_r[0][i]);
      dr[i] = 33'(pt_r[3][i]) - 33'(pt_r[2][i]);
    end

  assign req.start = (st_r == S_T1 || st_r == S_T2) && !second_r;
  assign req.p0 = dp[0]; assign req.p1 = dp[1]; assign req.p2 = dp[2];
  // right neighbour on the left edge or in the second interior test
  logic use_r;
  assign use_r = (j_r == left_r) || st_r == S_T2;
  assign req.q0 = use_r ? dr[0] : dq[0];
  assign req.q1 = use_r ? dr[1] : dq[1];
  assign req.q2 = use_r ? dr[2] : dq[2];

  gscm_nbtest u_nbt (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  logic plain;
  assign plain = (j_r < left_r) || (j_r > right_r) || (left_r == right_r) ||
                 (dp[0] == 0 && dp[1] == 0 && dp[2] == 0);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_valid) st_nxt = (in_op == OP_WRITE) ? S_WR : S_RD;
      S_WR:   st_nxt = S_IDLE;
      S_RD:   if (rk_r == 3'd4) st_nxt = S_DEC;
      S_DEC:  st_nxt = plain ? S_CALC : S_T1;
      S_T1:   if (rsp.done)
                st_nxt = (j_r != left_r && j_r != right_r && rsp.res == NB_OK)
                         ? S_T2 : S_CALC;
      S_T2:   if (rsp.done) st_nxt = S_CALC;
      S_CALC: st_nxt = S_OUT;
      S_OUT:  if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; rk_r <= '0; second_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rk_r <= (st_r == S_RD) ? rk_r + 3'd1 : 3'd0;
      // hold start low while a test runs
      if (st_r != st_nxt) second_r <= 1'b0;
      else if (req.start) second_r <= 1'b1;
    end
  end

  // combinational midpoint arithmetic with saturation
  logic signed [36:0] m, b1, b2, v;
  logic signed [31:0] res_c [3];
  always_comb
    for (int i = 0; i < 3; i++) begin
      m  = 37'(pt_r[1][i]) + 37'(pt_r[2][i]);
      b2 = 37'(pt_r[0][i]) - (37'(pt_r[1][i]) <<< 1) + 37'(pt_r[2][i]);
      b1 = 37'(pt_r[1][i]) - (37'(pt_r[2][i]) <<< 1) + 37'(pt_r[3][i]);
      if (use1_r && use2_r) v = ((m <<< 3) - b1 - b2) >>> 4;
      else if (use1_r) v = ((m <<< 2) - b1) >>> 3;
      else if (use2_r) v = ((m <<< 2) - b2) >>> 3;
      else v = m >>> 1;
      if (v > 37'sd2147483647) res_c[i] = 32'sh7fffffff;
      else if (v < -37'sd2147483648) res_c[i] = 32'sh80000000;
      else res_c[i] = v[31:0];
    end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_valid) begin
      j_r <= in_point_index;
      wdata_r <= {in_coord_z, in_coord_y, in_coord_x};
      use1_r <= 1'b0; use2_r <= 1'b0; code_r <= FIT_NONE;
    end
    // data of step k arrives from the registered read port in the next cycle
    if (st_r == S_RD && rk_r != 3'd0)
      for (int i = 0; i < 3; i++) pt_r[rk_r[1:0] - 2'd1][i] <= rdata_r[32*i +: 32];
    if (st_r == S_T1 && rsp.done) begin
      if (j_r == left_r) begin
        if (rsp.res == NB_OK) begin use1_r <= 1'b1; code_r <= FIT_LEFT; end
        else code_r <= FIT_LREJ;
      end else if (j_r == right_r) begin
        if (rsp.res == NB_OK) begin use2_r <= 1'b1; code_r <= FIT_RIGHT; end
        else code_r <= FIT_RREJ;
      end else if (rsp.res == NB_OK) use2_r <= 1'b1;
      else if (rsp.res == NB_REJECT) code_r <= FIT_RREJ;
    end
    if (st_r == S_T2 && rsp.done && rsp.res == NB_OK) begin
      use1_r <= 1'b1; code_r <= FIT_TWO;
    end
    if (st_r == S_CALC) begin
      out_mid_x <= res_c[0]; out_mid_y <= res_c[1]; out_mid_z <= res_c[2];
      out_fit_case <= code_r;
    end
  end

  assign out_valid = (st_r == S_OUT);
endmodule

FILE: sv/gscm_nbtest.sv
// Multi-cycle neighbour test: direction and length ratio of two difference vectors.
// Depends on gscm_pkg. One 33x33 signed product per cycle for the sums, then
// one 34x34 unsigned limb product per cycle for the wide compares.
`timescale 1ns / 1ps
module gscm_nbtest (
  input  logic              clk,
  input  logic              rst_n,
  input  gscm_pkg::nbt_req_t req,
  output gscm_pkg::nbt_rsp_t rsp
);
  import gscm_pkg::*;

  typedef enum logic [3:0] {S_IDLE = 4'b0001, S_MUL = 4'b0010, S_CMP = 4'b0100,
                            S_DONE = 4'b1000} st_t;
  st_t st_r, st_nxt;
  logic [3:0] k_r;
  logic signed [32:0] p_r [3];
  logic signed [32:0] q_r [3];
  logic signed [67:0] lp_r, lq_r, dot_r;   // sums of products
  logic [135:0] dd_r, lpq_r;               // dot^2 and |p|^2*|q|^2
  logic [87:0] rq_r, rp_r, p9_r;           // ratio products
  logic degen_r;
  nb_t res_r;

  // operands chosen by step: 0..2 p*p, 3..5 q*q, 6..8 p*q
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  always_comb begin
    ma = '0; mb = '0;
    case (k_r)
      4'd0, 4'd1, 4'd2: begin ma = p_r[k_r[1:0]]; mb = p_r[k_r[1:0]]; end
      4'd3, 4'd4, 4'd5: begin ma = q_r[k_r[1:0]-2'd3]; mb = q_r[k_r[1:0]-2'd3]; end
      4'd6: begin ma = p_r[0]; mb = q_r[0]; end
      4'd7: begin ma = p_r[1]; mb = q_r[1]; end
      4'd8: begin ma = p_r[2]; mb = q_r[2]; end
      default: ;
    endcase
    prod = ma * mb;
  end

  // wide products split into 34-bit limbs: 0..3 dot*dot, 4..7 lp*lq,
  // 8..9 lq*1000000, 10..11 lp*110889, 12..13 lp*9, step 14 decides
  logic [67:0] dot_u, lp_u, lq_u;
  logic [33:0] ua, ub;
  logic [67:0] uprod;
  assign dot_u = dot_r[67:0];
  assign lp_u  = lp_r[67:0];
  assign lq_u  = lq_r[67:0];
  always_comb begin
    ua = '0; ub = '0;
    case (k_r)
      4'd0:  begin ua = dot_u[33:0];  ub = dot_u[33:0];  end
      4'd1:  begin ua = dot_u[33:0];  ub = dot_u[67:34]; end
      4'd2:  begin ua = dot_u[67:34]; ub = dot_u[33:0];  end
      4'd3:  begin ua = dot_u[67:34]; ub = dot_u[67:34]; end
      4'd4:  begin ua = lp_u[33:0];   ub = lq_u[33:0];   end
      4'd5:  begin ua = lp_u[33:0];   ub = lq_u[67:34];  end
      4'd6:  begin ua = lp_u[67:34];  ub = lq_u[33:0];   end
      4'd7:  begin ua = lp_u[67:34];  ub = lq_u[67:34];  end
      4'd8:  begin ua = lq_u[33:0];   ub = 34'd1000000;  end
      4'd9:  begin ua = lq_u[67:34];  ub = 34'd1000000;  end
      4'd10: begin ua = lp_u[33:0];   ub = 34'd110889;   end
      4'd11: begin ua = lp_u[67:34];  ub = 34'd110889;   end
      4'd12: begin ua = lp_u[33:0];   ub = 34'd9;        end
      4'd13: begin ua = lp_u[67:34];  ub = 34'd9;        end
      default: ;
    endcase
    uprod = ua * ub;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (req.start) st_nxt = S_MUL;
      S_MUL:  if (k_r == 4'd8) st_nxt = S_CMP;
      S_CMP:  if (k_r == 4'd14) st_nxt = S_DONE;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      k_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_IDLE || (st_r == S_MUL && k_r == 4'd8) ||
          (st_r == S_CMP && k_r == 4'd14)) k_r <= '0;
      else k_r <= k_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: if (req.start) begin
        p_r[0] <= req.p0; p_r[1] <= req.p1; p_r[2] <= req.p2;
        q_r[0] <= req.q0; q_r[1] <= req.q1; q_r[2] <= req.q2;
        degen_r <= (req.q0 == 0) && (req.q1 == 0) && (req.q2 == 0);
        lp_r <= '0; lq_r <= '0; dot_r <= '0;
      end
      S_MUL: begin
        if (k_r < 4'd3) lp_r <= lp_r + 68'(prod);
        else if (k_r < 4'd6) lq_r <= lq_r + 68'(prod);
        else dot_r <= dot_r + 68'(prod);
      end
      S_CMP: begin
        case (k_r)
          4'd0:        dd_r <= 136'(uprod);
          4'd1, 4'd2:  dd_r <= dd_r + {34'd0, uprod, 34'd0};
          4'd3:        dd_r <= dd_r + {uprod, 68'd0};
          4'd4:        lpq_r <= 136'(uprod);
          4'd5, 4'd6:  lpq_r <= lpq_r + {34'd0, uprod, 34'd0};
          4'd7:        lpq_r <= lpq_r + {uprod, 68'd0};
          4'd8:        rq_r <= 88'(uprod);
          4'd9:        rq_r <= rq_r + {uprod[53:0], 34'd0};
          4'd10:       rp_r <= 88'(uprod);
          4'd11:       rp_r <= rp_r + {uprod[53:0], 34'd0};
          4'd12:       p9_r <= 88'(uprod);
          4'd13:       p9_r <= p9_r + {uprod[53:0], 34'd0};
          default: begin
            if (degen_r) res_r <= NB_DEGEN;
            else if (dot_r < 0 || {dd_r[134:0], 1'b0} < lpq_r ||
                     rq_r < rp_r || 88'(lq_u) > p9_r) res_r <= NB_REJECT;
            else res_r <= NB_OK;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign rsp.done = (st_r == S_DONE);
  assign rsp.res  = res_r;
endmodule

FILE: sv/gscm_checker.sv
// Port-level checker for the curved segment midpoint unit, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
module gscm_props (
  input logic clk, rst_n, in_valid, in_ready, in_op, out_valid, out_ready,
  input logic [2:0] out_fit_case
);
  a_fit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fit_case <= 3'd5) else $error("bad fit case");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fit_case))
    else $error("result dropped");
  a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result waits");
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_op |=> !out_valid) else $error("write gave result");
endmodule

bind grid_segment_curved_midpoint_unit gscm_props u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
  .out_valid(out_valid), .out_ready(out_ready), .out_fit_case(out_fit_case));
